// ----- hw/rtl/afsd_pkg.sv -----
// ----------------------------------------------------------------------------
// afsd_pkg: shared types and constants of the flip and shake detector
// Gesture codes, register indexes, register reset values and the per-sample
// update record passed from the evaluator to the top level.
// ----------------------------------------------------------------------------
package afsd_pkg;

    typedef enum logic [1:0] {
        GESTURE_NONE  = 2'd0,
        GESTURE_FLIP  = 2'd1,
        GESTURE_SHAKE = 2'd2
    } gesture_t;

    // configuration register indexes
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] CFG_FLIP_THRESHOLD   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHAKE_THRESHOLD  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_DEAD_ZONE        = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHAKES_NEEDED    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_SHAKE_GAP_LIMIT  = 3'd4;

    // register field widths
    localparam int THR_W     = 15;
    localparam int COUNT_W   = 8;
    localparam int TIMEOUT_W = 16;

    // register reset values
    localparam logic [THR_W-1:0]     FLIP_THRESHOLD_RST   = 15'd200;
    localparam logic [THR_W-1:0]     SHAKE_THRESHOLD_RST  = 15'd200;
    localparam logic [THR_W-1:0]     DEAD_ZONE_RST        = 15'd50;
    localparam logic [COUNT_W-1:0]   SHAKES_NEEDED_RST    = 8'd3;
    localparam logic [TIMEOUT_W-1:0] SHAKE_GAP_LIMIT_RST  = 16'd1000;

    // width of the flip compare: a full 16-bit sample against -(2^15-1)
    localparam int ZCMP_W = 17;

    // width of a squared threshold
    localparam int THR_SQ_W = 2 * THR_W;

    // state update decided for one sample
    typedef struct packed {
        gesture_t             gesture;
        logic                 take_ref;
        logic                 have_ref;
        logic [COUNT_W-1:0]   tally;
        logic                 stamp_time;
    } afsd_upd_t;

endpackage

// ----- hw/rtl/accel_flip_shake_detector_top.sv -----
// ----------------------------------------------------------------------------
// accel_flip_shake_detector_top: accelerometer flip and shake detector
// Takes one timestamped x,y,z sample per transaction and returns one gesture
// code (none, flip, shake) per sample.
// ----------------------------------------------------------------------------
// path: input register, then the evaluator and the state it updates, then
//   the result register, which holds its result while the output is stalled
// throughput: one sample per cycle unless the output stalls, one sample per
//   pass through the evaluator
// reset: asynchronous active low; clears reference, shake count, timestamps,
//   pipeline valid flags and loads the register reset values
module accel_flip_shake_detector_top #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    // configuration write port
    input  logic                                 cfg_wr_en,
    input  logic [afsd_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [afsd_pkg::CFG_DATA_W-1:0]      cfg_wdata,

    // sample channel
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic                                 read_ok,
    input  logic signed [15:0]                   accel_x,
    input  logic signed [15:0]                   accel_y,
    input  logic signed [15:0]                   accel_z,
    input  logic [31:0]                          now_ms,

    // gesture channel
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [1:0]                           gesture
);

    // configuration registers
    logic [afsd_pkg::THR_W-1:0]     flip_threshold_reg;
    logic [afsd_pkg::THR_W-1:0]     shake_threshold_reg;
    logic [afsd_pkg::THR_W-1:0]     dead_zone_reg;
    logic [afsd_pkg::COUNT_W-1:0]   shakes_needed_reg;
    logic [afsd_pkg::TIMEOUT_W-1:0] shake_gap_limit_reg;

    // input register stage
    logic                           s1_valid_reg;
    logic                           s1_ok_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_y_reg;
    logic signed [SAMPLE_WIDTH-1:0] s1_z_reg;
    logic [TIME_WIDTH-1:0]          s1_now_reg;

    // detector state
    logic signed [SAMPLE_WIDTH-1:0] ref_x_reg;
    logic signed [SAMPLE_WIDTH-1:0] ref_y_reg;
    logic signed [SAMPLE_WIDTH-1:0] ref_z_reg;
    logic                           have_ref_reg;
    logic [afsd_pkg::COUNT_W-1:0]   tally_reg;
    logic [TIME_WIDTH-1:0]          last_time_reg;

    // result register
    logic                           out_valid_reg;
    afsd_pkg::gesture_t             gesture_reg;

    afsd_pkg::afsd_upd_t            upd;
    logic                           in_fire;
    logic                           advance;

    // the staged sample moves into the result register whenever that register
    // is empty or being drained; the state update happens on the same edge
    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    // the input stage frees up when empty or moving on, even if a result waits
    assign in_ready = !s1_valid_reg || !out_valid_reg || out_ready;
    assign in_fire  = in_valid && in_ready;

    assign out_valid = out_valid_reg;
    assign gesture   = gesture_reg;

    // configuration writes, no read-back; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flip_threshold_reg   <= afsd_pkg::FLIP_THRESHOLD_RST;
            shake_threshold_reg  <= afsd_pkg::SHAKE_THRESHOLD_RST;
            dead_zone_reg        <= afsd_pkg::DEAD_ZONE_RST;
            shakes_needed_reg    <= afsd_pkg::SHAKES_NEEDED_RST;
            shake_gap_limit_reg  <= afsd_pkg::SHAKE_GAP_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                afsd_pkg::CFG_FLIP_THRESHOLD:
                    flip_threshold_reg <= cfg_wdata[afsd_pkg::THR_W-1:0];
                afsd_pkg::CFG_SHAKE_THRESHOLD:
                    shake_threshold_reg <= cfg_wdata[afsd_pkg::THR_W-1:0];
                afsd_pkg::CFG_DEAD_ZONE:
                    dead_zone_reg <= cfg_wdata[afsd_pkg::THR_W-1:0];
                afsd_pkg::CFG_SHAKES_NEEDED:
                    shakes_needed_reg <= cfg_wdata[afsd_pkg::COUNT_W-1:0];
                afsd_pkg::CFG_SHAKE_GAP_LIMIT:
                    shake_gap_limit_reg <= cfg_wdata[afsd_pkg::TIMEOUT_W-1:0];
                default:
                    ;
            endcase
        end
    end

    // input stage valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (advance)
            s1_valid_reg <= 1'b0;
    end

    // input stage payload: only the low sample and time bits are kept
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_ok_reg  <= read_ok;
            s1_x_reg   <= accel_x[SAMPLE_WIDTH-1:0];
            s1_y_reg   <= accel_y[SAMPLE_WIDTH-1:0];
            s1_z_reg   <= accel_z[SAMPLE_WIDTH-1:0];
            s1_now_reg <= now_ms[TIME_WIDTH-1:0];
        end
    end

    afsd_eval #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_eval (
        .read_ok          (s1_ok_reg),
        .x                (s1_x_reg),
        .y                (s1_y_reg),
        .z                (s1_z_reg),
        .now              (s1_now_reg),
        .have_ref         (have_ref_reg),
        .ref_x            (ref_x_reg),
        .ref_y            (ref_y_reg),
        .ref_z            (ref_z_reg),
        .tally            (tally_reg),
        .last_time        (last_time_reg),
        .flip_threshold   (flip_threshold_reg),
        .shake_threshold  (shake_threshold_reg),
        .dead_zone        (dead_zone_reg),
        .shakes_needed    (shakes_needed_reg),
        .shake_gap_limit  (shake_gap_limit_reg),
        .upd              (upd)
    );

    // detector state, committed as the sample's result is registered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_x_reg     <= '0;
            ref_y_reg     <= '0;
            ref_z_reg     <= '0;
            have_ref_reg  <= 1'b0;
            tally_reg     <= '0;
            last_time_reg <= '0;
        end
        else if (advance)
        begin
            have_ref_reg <= upd.have_ref;
            tally_reg    <= upd.tally;
            if (upd.take_ref)
            begin
                ref_x_reg <= s1_x_reg;
                ref_y_reg <= s1_y_reg;
                ref_z_reg <= s1_z_reg;
            end
            if (upd.stamp_time)
                last_time_reg <= s1_now_reg;
        end
    end

    // result register valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
            gesture_reg <= upd.gesture;
    end

endmodule

// ----- hw/rtl/afsd_eval.sv -----
// ----------------------------------------------------------------------------
// afsd_eval: single-sample gesture evaluation
// Flip test, squared distance from the reference against the larger of the
// squared dead zone and shake threshold, shake count with timeout.
// ----------------------------------------------------------------------------
module afsd_eval #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int TIME_WIDTH   = 32
) (
    input  logic                                 read_ok,
    input  logic signed [SAMPLE_WIDTH-1:0]       x,
    input  logic signed [SAMPLE_WIDTH-1:0]       y,
    input  logic signed [SAMPLE_WIDTH-1:0]       z,
    input  logic        [TIME_WIDTH-1:0]         now,
    input  logic                                 have_ref,
    input  logic signed [SAMPLE_WIDTH-1:0]       ref_x,
    input  logic signed [SAMPLE_WIDTH-1:0]       ref_y,
    input  logic signed [SAMPLE_WIDTH-1:0]       ref_z,
    input  logic        [afsd_pkg::COUNT_W-1:0]  tally,
    input  logic        [TIME_WIDTH-1:0]         last_time,
    input  logic        [afsd_pkg::THR_W-1:0]    flip_threshold,
    input  logic        [afsd_pkg::THR_W-1:0]    shake_threshold,
    input  logic        [afsd_pkg::THR_W-1:0]    dead_zone,
    input  logic        [afsd_pkg::COUNT_W-1:0]  shakes_needed,
    input  logic        [afsd_pkg::TIMEOUT_W-1:0] shake_gap_limit,
    output afsd_pkg::afsd_upd_t                  upd
);

    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int SQ_W   = 2 * SAMPLE_WIDTH + 2;
    localparam int CMP_W  = (SQ_W > afsd_pkg::THR_SQ_W) ? SQ_W : afsd_pkg::THR_SQ_W;

    logic [DIFF_W-1:0]               dx, dy, dz;
    logic [DIFF_W-1:0]               ax, ay, az;
    logic [SQ_W-1:0]                 sqx, sqy, sqz;
    logic [SQ_W-1:0]                 dist_sq;
    logic [afsd_pkg::THR_W-1:0]      thr_max;
    logic [afsd_pkg::THR_SQ_W-1:0]   thr_sq;
    logic                            shaking;
    logic signed [afsd_pkg::ZCMP_W-1:0] z_ext;
    logic signed [afsd_pkg::ZCMP_W-1:0] neg_flip;
    logic                            flip_hit;
    logic [TIME_WIDTH-1:0]           gap;
    logic                            timed_out;
    logic [afsd_pkg::COUNT_W-1:0]    tally_inc;

    // differences in one extra bit, then magnitudes
    assign dx = DIFF_W'(x) - DIFF_W'(ref_x);
    assign dy = DIFF_W'(y) - DIFF_W'(ref_y);
    assign dz = DIFF_W'(z) - DIFF_W'(ref_z);

    assign ax = dx[DIFF_W-1] ? (~dx + DIFF_W'(1)) : dx;
    assign ay = dy[DIFF_W-1] ? (~dy + DIFF_W'(1)) : dy;
    assign az = dz[DIFF_W-1] ? (~dz + DIFF_W'(1)) : dz;

    assign sqx     = SQ_W'(ax) * SQ_W'(ax);
    assign sqy     = SQ_W'(ay) * SQ_W'(ay);
    assign sqz     = SQ_W'(az) * SQ_W'(az);
    assign dist_sq = sqx + sqy + sqz;

    // both bounds hold exactly when the larger one does
    assign thr_max = (dead_zone > shake_threshold) ? dead_zone : shake_threshold;
    assign thr_sq  = afsd_pkg::THR_SQ_W'(thr_max) * afsd_pkg::THR_SQ_W'(thr_max);
    assign shaking = CMP_W'(dist_sq) >= CMP_W'(thr_sq);

    assign z_ext    = afsd_pkg::ZCMP_W'(z);
    assign neg_flip = afsd_pkg::ZCMP_W'(0) - $signed({2'b00, flip_threshold});
    assign flip_hit = z_ext < neg_flip;

    assign gap       = now - last_time;
    assign timed_out = gap > TIME_WIDTH'(shake_gap_limit);
    assign tally_inc = (timed_out ? '0 : tally) + afsd_pkg::COUNT_W'(1);

    always_comb
    begin
        upd.gesture    = afsd_pkg::GESTURE_NONE;
        upd.take_ref   = 1'b0;
        upd.have_ref   = have_ref;
        upd.tally      = tally;
        upd.stamp_time = 1'b0;
        if (!read_ok)
        begin
            upd.have_ref = 1'b0;
            upd.tally    = '0;
        end
        else if (!have_ref)
        begin
            upd.take_ref = 1'b1;
            upd.have_ref = 1'b1;
        end
        else if (flip_hit)
        begin
            upd.take_ref = 1'b1;
            upd.gesture  = afsd_pkg::GESTURE_FLIP;
        end
        else if (shaking)
        begin
            upd.stamp_time = 1'b1;
            if (tally_inc >= shakes_needed)
            begin
                upd.tally    = '0;
                upd.take_ref = 1'b1;
                upd.gesture  = afsd_pkg::GESTURE_SHAKE;
            end
            else
            begin
                upd.tally = tally_inc;
            end
        end
        else
        begin
            upd.take_ref = 1'b1;
        end
    end

endmodule

// ----- hw/rtl/afsd_checker.sv -----
// ----------------------------------------------------------------------------
// afsd_checker: port-level checks for the flip and shake detector
// Watches the handshakes on the top level and flags flow-control slips.
// ----------------------------------------------------------------------------
module afsd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] gesture
);

    // a stalled result holds its value
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(gesture);
    endproperty
    a_out_hold: assert property (p_out_hold)
        else $error("stalled gesture transaction changed or dropped");

    // input backpressure only comes from a stalled result
    property p_ready_cause;
        @(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready;
    endproperty
    a_ready_cause: assert property (p_ready_cause)
        else $error("input stalled while result side is free");

    // two storage places: a transaction taken behind a stalled result fills them
    property p_full_stall;
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && out_valid && !out_ready) ##1 !out_ready |-> !in_ready;
    endproperty
    a_full_stall: assert property (p_full_stall)
        else $error("input accepted with no room left");

    // after reset the block is empty and open for input
    property p_reset_empty;
        @(posedge clk)
        !rst_n |=> in_ready && !out_valid;
    endproperty
    a_reset_empty: assert property (p_reset_empty)
        else $error("block not empty after reset");

endmodule

bind accel_flip_shake_detector_top afsd_checker u_afsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .gesture   (gesture)
);
